// ===== hw/rtl/hitc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hall ignition timing controller package
// Shared constants and request codes for the ignition timing controller.
// ----------------------------------------------------------------------------
package hitc_pkg;

    typedef enum logic {
        REQ_TICK  = 1'b0,
        REQ_WRITE = 1'b1
    } req_t;

    localparam logic [7:0]  COUNT_LIMIT    = 8'd239;
    localparam logic [7:0]  INDEX_LIMIT    = 8'd240;
    localparam logic [7:0]  DEBOUNCE_RESET = 8'd3;
    localparam int unsigned COUNT_W        = 8;
    localparam int unsigned DWELL_W        = 16;

endpackage

// ===== hw/rtl/hitc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hitc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/hall_ignition_timing_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hall ignition timing controller
// Debounces the Hall sensor, times dwell and spark, and holds the advance
// table that maps the previous sector tick count to the next spark point.
//
// Input items arrive on in_valid / in_stall; a transfer is either a timer
// tick or an advance table write, selected by req_type. Every input transfer
// produces exactly one result transfer on out_valid / out_stall carrying the
// coil and indicator levels, the sensor state, the last sector count and the
// current spark point.
// Each input transfer passes the staging register and then the output register
// before result valid. One item is accepted every cycle while the receiver
// takes results; the advance table read at shutter exit is registered in the
// RAM and its data is forwarded to the following item, so no bubble is needed.
// When the receiver stalls, the output register and one staging register
// fill, after which in_stall rises until the output drains.
// Reset clears all timing state and sets the debounce length to three; the
// advance table is not cleared and must be loaded before it is used.
// ----------------------------------------------------------------------------
module hall_ignition_timing_controller #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       req_type,
    input  logic       hall_in,
    input  logic       engine_stop,
    input  logic       rev_limit_one,
    input  logic       rev_limit_two,
    input  logic       coil_off_set,
    input  logic [7:0] table_index,
    input  logic [7:0] table_value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       coil_on,
    output logic       led_on,
    output logic       sensor_state,
    output logic [7:0] last_sector_count,
    output logic [7:0] spark_point
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [8:0] DEPTH_LIMIT = 9'(TABLE_DEPTH);

    logic [7:0]  debounce_cfg_reg;
    logic [7:0]  debounce_count_reg, debounce_count_next;
    logic        sensor_flag_reg, sensor_flag_next;
    logic        prev_in_reg, prev_in_next;
    logic [7:0]  tick_count_reg, tick_count_next;
    logic [7:0]  saved_count_reg, saved_count_next;
    logic        overflow_reg, overflow_next;
    logic [7:0]  spark_ticks_reg, spark_ticks_next;
    logic [15:0] dwell_reg, dwell_next;
    logic        coil_off_reg, coil_off_next;
    logic        coil_level_reg, coil_level_next;
    logic        led_level_reg, led_level_next;
    logic        pend_reg;

    logic        s1_valid_reg;
    logic        s1_use_ram_reg;
    logic        s1_coil_reg, s1_led_reg, s1_sensor_reg;
    logic [7:0]  s1_saved_reg, s1_spark_reg;

    logic        out_valid_reg;
    logic        out_coil_reg, out_led_reg, out_sensor_reg;
    logic [7:0]  out_saved_reg, out_spark_reg;

    logic        in_accept, s1_adv;
    logic        is_tick;
    logic        blocked;
    logic        rd_en, rd_ok;
    logic        wr_en;
    logic [7:0]  rd_data;
    logic [7:0]  spark_eff;
    logic [7:0]  count_inc;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;
    assign is_tick   = (hitc_pkg::req_t'(req_type) == hitc_pkg::REQ_TICK);
    assign blocked   = engine_stop || rev_limit_one || rev_limit_two;
    assign spark_eff = pend_reg ? rd_data : spark_ticks_reg;
    assign wr_en     = in_accept && !is_tick && ({1'b0, table_index} < DEPTH_LIMIT);
    assign rd_ok     = (tick_count_reg <= hitc_pkg::INDEX_LIMIT)
                    && ({1'b0, tick_count_reg} < DEPTH_LIMIT);

    always_comb
    begin
        debounce_count_next = debounce_count_reg;
        sensor_flag_next    = sensor_flag_reg;
        prev_in_next        = prev_in_reg;
        tick_count_next     = tick_count_reg;
        saved_count_next    = saved_count_reg;
        overflow_next       = overflow_reg;
        spark_ticks_next    = spark_eff;
        dwell_next          = dwell_reg;
        coil_off_next       = coil_off_reg || coil_off_set;
        coil_level_next     = coil_level_reg;
        led_level_next      = led_level_reg;
        rd_en               = 1'b0;
        count_inc           = tick_count_reg + 8'd1;

        if (is_tick)
        begin
            if (hall_in == sensor_flag_reg)
            begin
                debounce_count_next = '0;
            end
            else
            begin
                debounce_count_next = debounce_count_reg + 8'd1;
                if (debounce_count_next == debounce_cfg_reg)
                begin
                    sensor_flag_next    = !sensor_flag_reg;
                    debounce_count_next = '0;
                end
            end

            if (sensor_flag_next)
            begin
                if (!prev_in_reg)
                begin
                    if (!blocked)
                    begin
                        coil_level_next = 1'b1;
                    end
                    saved_count_next = tick_count_reg;
                    tick_count_next  = '0;
                    prev_in_next     = 1'b1;
                    overflow_next    = 1'b0;
                    coil_off_next    = 1'b0;
                end
                else
                begin
                    led_level_next = 1'b0;
                    if (!overflow_reg)
                    begin
                        tick_count_next = count_inc;
                        if (count_inc >= hitc_pkg::COUNT_LIMIT)
                        begin
                            overflow_next = 1'b1;
                        end
                        if (spark_eff != '0 && count_inc == spark_eff)
                        begin
                            coil_level_next = 1'b0;
                        end
                    end
                end
            end
            else if (prev_in_reg)
            begin
                coil_level_next = 1'b0;
                prev_in_next    = 1'b0;
                dwell_next      = 16'(tick_count_reg)
                                + ((spark_eff == '0) ? 16'(hitc_pkg::COUNT_LIMIT)
                                                     : 16'(spark_eff));
                rd_en           = rd_ok;
                if (!rd_ok)
                begin
                    spark_ticks_next = '0;
                end
            end
            else
            begin
                led_level_next = 1'b1;
                dwell_next     = dwell_reg - 16'd1;
                if (dwell_next == '0 && !blocked && !coil_off_next)
                begin
                    coil_level_next = 1'b1;
                end
            end
        end
    end

    hitc_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (table_index[AW-1:0]),
        .wr_data (table_value),
        .rd_en   (in_accept && rd_en),
        .rd_addr (tick_count_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_cfg_reg   <= hitc_pkg::DEBOUNCE_RESET;
            debounce_count_reg <= '0;
            sensor_flag_reg    <= 1'b0;
            prev_in_reg        <= 1'b0;
            tick_count_reg     <= '0;
            saved_count_reg    <= '0;
            overflow_reg       <= 1'b0;
            spark_ticks_reg    <= '0;
            dwell_reg          <= '0;
            coil_off_reg       <= 1'b0;
            coil_level_reg     <= 1'b0;
            led_level_reg      <= 1'b0;
            pend_reg           <= 1'b0;
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                debounce_cfg_reg <= cfg_wr_data;
            end
            if (in_accept)
            begin
                debounce_count_reg <= debounce_count_next;
                sensor_flag_reg    <= sensor_flag_next;
                prev_in_reg        <= prev_in_next;
                tick_count_reg     <= tick_count_next;
                saved_count_reg    <= saved_count_next;
                overflow_reg       <= overflow_next;
                spark_ticks_reg    <= spark_ticks_next;
                dwell_reg          <= dwell_next;
                coil_off_reg       <= coil_off_next;
                coil_level_reg     <= coil_level_next;
                led_level_reg      <= led_level_next;
                pend_reg           <= rd_en;
            end
            else
            begin
                if (pend_reg)
                begin
                    spark_ticks_reg <= rd_data;
                end
                pend_reg <= 1'b0;
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_use_ram_reg <= rd_en;
            s1_coil_reg    <= coil_level_next;
            s1_led_reg     <= led_level_next;
            s1_sensor_reg  <= sensor_flag_next;
            s1_saved_reg   <= saved_count_next;
            s1_spark_reg   <= spark_ticks_next;
        end
        if (s1_adv)
        begin
            out_coil_reg   <= s1_coil_reg;
            out_led_reg    <= s1_led_reg;
            out_sensor_reg <= s1_sensor_reg;
            out_saved_reg  <= s1_saved_reg;
            out_spark_reg  <= s1_use_ram_reg ? rd_data : s1_spark_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign coil_on           = out_coil_reg;
    assign led_on            = out_led_reg;
    assign sensor_state      = out_sensor_reg;
    assign last_sector_count = out_saved_reg;
    assign spark_point       = out_spark_reg;

endmodule
